// ===== hdl/nonuniform_grid_finite_difference_top_assert.svh =====
// Assertion macros for the nonuniform grid finite difference block
`ifndef NONUNIFORM_GRID_FINITE_DIFFERENCE_TOP_ASSERT_SVH
`define NONUNIFORM_GRID_FINITE_DIFFERENCE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define NGFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define NGFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ngfd_pkg.sv =====
// Package: types, widths and codes of the nonuniform grid finite difference block
`timescale 1ns / 1ps
package ngfd_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int CNT_W  = 16;
    localparam int NUM_W  = DATA_W + 4;
    localparam int DIF_W  = DATA_W + 1;
    localparam int DEN_W  = 2 * DIF_W;
    localparam int DIVN_W = NUM_W + 2 * FRAC_W;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_ORDER  = 3'd1;
    localparam logic [2:0] ST_FEW    = 3'd2;
    localparam logic [2:0] ST_ACC    = 3'd3;
    localparam logic [2:0] ST_METHOD = 3'd4;
    localparam logic [2:0] ST_DIV0   = 3'd5;
    localparam logic [2:0] ST_SAT    = 3'd6;

    localparam logic [1:0] METH_BWD = 2'd0;
    localparam logic [1:0] METH_FWD = 2'd1;
    localparam logic [1:0] METH_CEN = 2'd2;
    localparam logic [1:0] METH_UPW = 2'd3;

    localparam logic [2:0] REG_METHOD = 3'd0;
    localparam logic [2:0] REG_DORDER = 3'd1;
    localparam logic [2:0] REG_AORDER = 3'd2;
    localparam logic [2:0] REG_COUNT  = 3'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic signed [DATA_W-1:0] coordinate;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] derivative;
        logic [CNT_W-1:0]         point_index;
        logic [2:0]               status;
        logic                     last_of_sweep;
    } t_out;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic signed [DIF_W-1:0] d1;
        logic signed [DIF_W-1:0] d2;
        logic                    two_den;
        logic                    ord2;
        logic [2:0]              status;
        logic [CNT_W-1:0]        index;
        logic                    last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_CHK,
        BK_DIV,
        BK_FIN,
        BK_EMIT
    } t_back_state;

endpackage

// ===== hdl/ngfd_front.sv =====
// Front end: configuration, point window and job generation
`timescale 1ns / 1ps
module ngfd_front import ngfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  t_in         i_in_data,
    output logic        o_in_stall,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_job        o_job
);

    typedef struct packed {
        logic [CNT_W:0]     i0, i1, i2;
        logic signed [3:0]  c0, c1, c2;
        logic [CNT_W:0]     a0, b0, a1, b1;
        logic               two;
    } t_recipe;

    function automatic t_recipe rc_diff(logic [CNT_W:0] a, logic [CNT_W:0] b);
        t_recipe r;
        r = '0;
        r.i0 = a; r.c0 = 4'sd1; r.i1 = b; r.c1 = -4'sd1;
        r.a0 = a; r.b0 = b;
        return r;
    endfunction

    function automatic t_recipe rc_curv(logic [CNT_W:0] l);
        t_recipe r;
        r = '0;
        r.i0 = l + 2'd2; r.c0 = 4'sd1;
        r.i1 = l + 1'd1; r.c1 = -4'sd2;
        r.i2 = l;        r.c2 = 4'sd1;
        r.a0 = l + 2'd2; r.b0 = l + 1'd1;
        r.a1 = l + 1'd1; r.b1 = l;
        r.two = 1'b1;
        return r;
    endfunction

    // {hit, slot}: window slot of point idx when k is the newest point
    function automatic logic [3:0] slot_of(logic [CNT_W-1:0] k, logic [CNT_W:0] idx);
        logic [CNT_W+1:0] d;
        d = {2'b00, k} - {1'b0, idx};
        if (!d[CNT_W+1] && d < (CNT_W+2)'(5)) begin
            return {1'b1, d[2:0]};
        end
        return 4'd0;
    endfunction

    logic [1:0]       r_method;
    logic [1:0]       r_dorder;
    logic [2:0]       r_aorder;
    logic [CNT_W-1:0] r_pcount;
    logic signed [DATA_W-1:0] r_vwin [5];
    logic signed [DATA_W-1:0] r_xwin [5];
    logic [CNT_W-1:0] r_k;
    logic [CNT_W-1:0] r_nk;
    logic [CNT_W-1:0] r_cur;
    logic [1:0]       r_rem;

    logic [CNT_W-1:0] cnt, lastp, first;
    logic             acc, k_last;
    logic [2:0]       st;
    t_recipe          rc;
    logic [3:0]       s0, s1, s2, sa0, sb0, sa1, sb1;
    logic signed [DATA_W-1:0] v0, v1, v2, xa0, xb0, xa1, xb1;

    assign acc        = i_in_valid && (r_rem == 2'd0);
    assign o_in_stall = (r_rem != 2'd0);
    assign o_push     = (r_rem != 2'd0) && !i_q_stat.full;

    assign cnt    = (r_pcount == '0) ? CNT_W'(1) : r_pcount;
    assign lastp  = cnt - 1'b1;
    assign k_last = ({1'b0, r_k} + 1'b1) >= {1'b0, cnt};
    assign first  = (r_k >= CNT_W'(2)) ? r_k - CNT_W'(2) : '0;

    always_comb begin
        logic [CNT_W:0] n;
        logic           is_first, is_last, nxt_last;
        n        = {1'b0, r_cur};
        is_first = (r_cur == '0);
        is_last  = (r_cur == lastp);
        nxt_last = (n + 1'b1) == {1'b0, lastp};
        st = ST_OK;
        if (r_method == METH_UPW) begin
            st = ST_METHOD;
        end else if (r_dorder != 2'd1 && r_dorder != 2'd2) begin
            st = ST_ORDER;
        end else if (r_method == METH_BWD) begin
            if (cnt < CNT_W'(3)) st = ST_FEW;
            else if (r_aorder != 3'd1) st = ST_ACC;
        end else if (r_method == METH_FWD) begin
            if (r_aorder != 3'd1) st = ST_ACC;
            else if (cnt < ((r_dorder == 2'd2) ? CNT_W'(4) : CNT_W'(3))) st = ST_FEW;
        end else begin
            if (r_aorder != 3'd2) st = ST_ACC;
            else if (cnt < CNT_W'(3)) st = ST_FEW;
        end

        rc = '0;
        case (r_method)
            METH_BWD: begin
                if (r_dorder == 2'd1) begin
                    rc = is_first ? rc_diff((CNT_W+1)'(1), '0) : rc_diff(n, n - 1'b1);
                end else begin
                    rc = rc_curv((r_cur <= CNT_W'(1)) ? '0 : n - 2'd2);
                end
            end
            METH_FWD: begin
                if (r_dorder == 2'd1) begin
                    rc = is_last ? rc_diff(n, n - 1'b1) : rc_diff(n + 1'b1, n);
                end else begin
                    rc = rc_curv(is_last ? n - 2'd2 : (nxt_last ? n - 1'b1 : n));
                end
            end
            default: begin
                if (r_dorder == 2'd1) begin
                    if (is_first) begin
                        rc = '0;
                        rc.i0 = '0;               rc.c0 = -4'sd3;
                        rc.i1 = (CNT_W+1)'(1);    rc.c1 = 4'sd4;
                        rc.i2 = (CNT_W+1)'(2);    rc.c2 = -4'sd1;
                        rc.a0 = (CNT_W+1)'(2);    rc.b0 = '0;
                    end else if (is_last) begin
                        rc = '0;
                        rc.i0 = n;          rc.c0 = 4'sd3;
                        rc.i1 = n - 1'b1;   rc.c1 = -4'sd4;
                        rc.i2 = n - 2'd2;   rc.c2 = 4'sd1;
                        rc.a0 = n;          rc.b0 = n - 2'd2;
                    end else begin
                        rc = rc_diff(n + 1'b1, n - 1'b1);
                    end
                end else begin
                    rc = rc_curv(is_first ? '0 : (is_last ? n - 2'd2 : n - 1'b1));
                end
            end
        endcase

        s0  = slot_of(r_nk, rc.i0);
        s1  = slot_of(r_nk, rc.i1);
        s2  = slot_of(r_nk, rc.i2);
        sa0 = slot_of(r_nk, rc.a0);
        sb0 = slot_of(r_nk, rc.b0);
        sa1 = slot_of(r_nk, rc.a1);
        sb1 = slot_of(r_nk, rc.b1);
        v0  = s0[3]  ? r_vwin[s0[2:0]]  : '0;
        v1  = s1[3]  ? r_vwin[s1[2:0]]  : '0;
        v2  = s2[3]  ? r_vwin[s2[2:0]]  : '0;
        xa0 = sa0[3] ? r_xwin[sa0[2:0]] : '0;
        xb0 = sb0[3] ? r_xwin[sb0[2:0]] : '0;
        xa1 = sa1[3] ? r_xwin[sa1[2:0]] : '0;
        xb1 = sb1[3] ? r_xwin[sb1[2:0]] : '0;

        o_job.num = NUM_W'(rc.c0) * NUM_W'(v0) + NUM_W'(rc.c1) * NUM_W'(v1)
                  + NUM_W'(rc.c2) * NUM_W'(v2);
        o_job.d1      = DIF_W'(xa0) - DIF_W'(xb0);
        o_job.d2      = DIF_W'(xa1) - DIF_W'(xb1);
        o_job.two_den = rc.two;
        o_job.ord2    = (r_dorder == 2'd2);
        o_job.status  = st;
        o_job.index   = r_cur;
        o_job.last    = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= METH_CEN;
            r_dorder <= 2'd1;
            r_aorder <= 3'd2;
            r_pcount <= CNT_W'(3);
            r_k      <= '0;
            r_rem    <= '0;
        end else begin
            if (o_push) begin
                r_cur <= r_cur + 1'b1;
                r_rem <= r_rem - 1'b1;
            end
            if (acc) begin
                r_nk  <= r_k;
                r_cur <= first;
                if (k_last) begin
                    r_rem <= 2'(r_k - first) + 2'd1;
                    r_k   <= '0;
                end else begin
                    r_rem <= (r_k >= CNT_W'(2)) ? 2'd1 : 2'd0;
                    r_k   <= r_k + 1'b1;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_METHOD: begin r_method <= i_cfg_data[1:0]; r_k <= '0; end
                    REG_DORDER: begin r_dorder <= i_cfg_data[1:0]; r_k <= '0; end
                    REG_AORDER: begin r_aorder <= i_cfg_data[2:0]; r_k <= '0; end
                    REG_COUNT:  begin r_pcount <= i_cfg_data[CNT_W-1:0]; r_k <= '0; end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int i = 4; i > 0; i--) begin
                r_vwin[i] <= r_vwin[i-1];
                r_xwin[i] <= r_xwin[i-1];
            end
            r_vwin[0] <= i_in_data.sample_value;
            r_xwin[0] <= i_in_data.coordinate;
        end
    end

endmodule

// ===== hdl/ngfd_job_fifo.sv =====
// Job queue between front end and arithmetic back end
`timescale 1ns / 1ps
module ngfd_job_fifo import ngfd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [LW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_cnt == LW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;
    assign o_job   = r_mem[r_rp];
    assign o_level = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (do_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + LW'(do_push) - LW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

endmodule

// ===== hdl/ngfd_back.sv =====
// Back end: serial multiply, restoring divide, saturation and output register
`timescale 1ns / 1ps
module ngfd_back import ngfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_q_stat,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_out    o_out_data
);

    localparam int CW = $clog2(DIVN_W + 1);

    t_back_state       r_state, n_state;
    logic [NUM_W-1:0]  r_nmag;
    logic              r_neg, r_nneg, r_ord2;
    logic [DEN_W-1:0]  r_dmag, r_mcand;
    logic [DIF_W-1:0]  r_mplier;
    logic [DIVN_W-1:0] r_dvd, r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [CW-1:0]     r_cnt;
    t_out              r_res;
    logic              r_ov;
    t_out              r_out;

    logic [NUM_W-1:0]  nmag;
    logic [DIF_W-1:0]  d1m, d2m;
    logic [DEN_W:0]    rem_sh;
    logic              q_ge;
    logic [DIVN_W-1:0] lim;
    logic              emit;

    localparam logic signed [DATA_W-1:0] MAXV = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MINV = {1'b1, {(DATA_W-1){1'b0}}};

    assign nmag   = i_job.num[NUM_W-1] ? NUM_W'(-i_job.num) : NUM_W'(i_job.num);
    assign d1m    = i_job.d1[DIF_W-1] ? DIF_W'(-i_job.d1) : DIF_W'(i_job.d1);
    assign d2m    = i_job.d2[DIF_W-1] ? DIF_W'(-i_job.d2) : DIF_W'(i_job.d2);
    assign rem_sh = {r_rem, r_dvd[DIVN_W-1]};
    assign q_ge   = rem_sh >= {1'b0, r_dmag};
    assign lim    = DIVN_W'(1) << (DATA_W - 1);
    assign emit   = (r_state == BK_EMIT) && (!r_ov || !i_out_stall);
    assign o_pop  = (r_state == BK_IDLE) && !i_q_stat.empty;

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (i_job.status != ST_OK) n_state = BK_EMIT;
                    else if (i_job.two_den)    n_state = BK_MUL;
                    else                       n_state = BK_CHK;
                end
            end
            BK_MUL:  if (r_cnt == CW'(1)) n_state = BK_CHK;
            BK_CHK:  n_state = (r_dmag == '0) ? BK_EMIT : BK_DIV;
            BK_DIV:  if (r_cnt == CW'(1)) n_state = BK_FIN;
            BK_FIN:  n_state = BK_EMIT;
            BK_EMIT: if (emit) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit)             r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_out <= r_res;
        case (r_state)
            BK_IDLE: begin
                r_res.point_index   <= i_job.index;
                r_res.last_of_sweep <= i_job.last;
                r_res.status        <= i_job.status;
                r_res.derivative    <= '0;
                r_nmag   <= nmag;
                r_nneg   <= i_job.num[NUM_W-1];
                r_neg    <= i_job.num[NUM_W-1] ^ i_job.d1[DIF_W-1]
                            ^ (i_job.two_den & i_job.d2[DIF_W-1]);
                r_ord2   <= i_job.ord2;
                r_mcand  <= DEN_W'(d1m);
                r_mplier <= d2m;
                r_dmag   <= i_job.two_den ? '0 : DEN_W'(d1m);
                r_cnt    <= CW'(DIF_W);
            end
            BK_MUL: begin
                if (r_mplier[0]) r_dmag <= r_dmag + r_mcand;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt - 1'b1;
            end
            BK_CHK: begin
                r_dvd <= r_ord2 ? DIVN_W'(r_nmag) << (2 * FRAC_W)
                                : DIVN_W'(r_nmag) << FRAC_W;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= CW'(DIVN_W);
                if (r_dmag == '0) begin
                    r_res.status     <= ST_DIV0;
                    r_res.derivative <= (r_nmag == '0) ? '0 : (r_nneg ? MINV : MAXV);
                end
            end
            BK_DIV: begin
                r_rem <= q_ge ? DEN_W'(rem_sh - {1'b0, r_dmag}) : DEN_W'(rem_sh);
                r_quo <= {r_quo[DIVN_W-2:0], q_ge};
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - 1'b1;
            end
            BK_FIN: begin
                if (!r_neg && r_quo >= lim) begin
                    r_res.status <= ST_SAT; r_res.derivative <= MAXV;
                end else if (r_neg && r_quo > lim) begin
                    r_res.status <= ST_SAT; r_res.derivative <= MINV;
                end else begin
                    r_res.status     <= ST_OK;
                    r_res.derivative <= r_neg ? -r_quo[DATA_W-1:0] : r_quo[DATA_W-1:0];
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/nonuniform_grid_finite_difference_top.sv =====
// Top level of the nonuniform grid finite difference block
// Usage:
//  Input channel: i_in_valid / o_in_stall carry one grid point per word
//  (sample value and coordinate, signed Q16.16). A word is taken on a rising
//  edge with valid high and stall low.
//  Output channel: o_out_valid / i_out_stall carry one derivative word with
//  point index, status and last-of-sweep flag, in point order.
//  Configuration: i_cfg_we writes register i_cfg_idx (0 method, 1 derivative
//  order, 2 accuracy order, 3 point count); each write to these restarts the sweep.
//  Jobs: the front end turns each point into up to three jobs, one a cycle
//  while the queue has room, into a job queue. The back end runs a serial
//  multiply for second derivatives and a restoring divide per result, and
//  takes the next job from the queue only once the last result is emitted.
//  Configuration errors skip the arithmetic.
//  Reset: synchronous, active low; registers return to central, first order,
//  accuracy 2, three points, and the queue and output register empty.
//  A stalled output keeps its word; the back end waits, the queue fills and
//  then the input stalls.
`timescale 1ns / 1ps
`include "nonuniform_grid_finite_difference_top_assert.svh"
module nonuniform_grid_finite_difference_top import ngfd_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data
);

    t_job    front_job, q_job;
    logic    push, pop;
    t_q_stat q_stat;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;

    // front end: registers, five-point window, formula selection
    ngfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_job      (front_job)
    );

    // decouples job generation from the long arithmetic
    ngfd_job_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_stat  (q_stat),
        .o_level (q_level)
    );

    // back end: shared serial multiplier and divider, output register
    ngfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `NGFD_ASSERT_IMP(a_q_bound, 1'b1, q_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "queue overfilled")
    `NGFD_ASSERT_IMP(a_err_zero, o_out_valid && (o_out_data.status == ST_ORDER || o_out_data.status == ST_FEW || o_out_data.status == ST_ACC || o_out_data.status == ST_METHOD), o_out_data.derivative == '0, "error word carries data")
    `NGFD_ASSERT_NXT(a_push_room, push && q_stat.full, 1'b0, "push into full queue")

endmodule
